[sv/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/ctr_pkg.sv]
// Types and constants of the CAN transport reassembly core.
`timescale 1ns / 1ps
`default_nettype none
package ctr_pkg;

   localparam int LANES = 8;

   typedef struct packed {
      logic        func;
      logic [3:0]  frame_dlc;
      logic [7:0]  pci_byte;
      logic [7:0]  frame_byte1;
      logic [7:0]  frame_byte2;
      logic [7:0]  frame_byte3;
      logic [7:0]  frame_byte4;
      logic [7:0]  frame_byte5;
      logic [7:0]  frame_byte6;
      logic [7:0]  frame_byte7;
      logic [11:0] read_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [11:0] msg_len;
      logic [7:0]  fc_byte0;
      logic [7:0]  fc_byte1;
      logic [7:0]  fc_byte2;
      logic [7:0]  read_data;
   } rsp_type;

   // bank command: write count bytes from base upward, or read at base
   typedef struct packed {
      logic            we;
      logic            rd;
      logic [11:0]     base;
      logic [2:0]      count;
      logic [7:0][7:0] data;
   } lane_cmd_type;

   localparam logic [2:0] EV_IGNORED   = 3'd0;
   localparam logic [2:0] EV_SINGLE    = 3'd1;
   localparam logic [2:0] EV_FIRST     = 3'd2;
   localparam logic [2:0] EV_CONSEC    = 3'd3;
   localparam logic [2:0] EV_DELIVERED = 3'd4;
   localparam logic [2:0] EV_ABORT     = 3'd5;
   localparam logic [2:0] EV_TOO_LONG  = 3'd6;
   localparam logic [2:0] EV_READ      = 3'd7;

   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST  = 4'h1;
   localparam logic [3:0] PCI_CONSEC = 4'h2;

   localparam logic [7:0] FC_CTS = 8'h30;

   localparam logic [1:0] CSR_FC_BS  = 2'd0;
   localparam logic [1:0] CSR_FC_ST  = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN = 2'd2;

   localparam logic [7:0]  FC_BS_RESET   = 8'd0;
   localparam logic [7:0]  FC_ST_RESET   = 8'd10;
   localparam logic [11:0] MAX_LEN_RESET = 12'd4095;

endpackage
`default_nettype wire

[sv/can_transport_reassembly_core.sv]
// Top level of the CAN transport reassembly core.
// Receive side of CAN transport (ISO 15765-2 style). Each transfer in is one CAN frame or one
// read of the message store, and gives exactly one transfer out. A result passes through decode,
// bank access and merge into the output register, and a new item is taken only after the result
// of the previous one has been loaded there; the output register lets the next item
// enter while a result still waits. The message store is split into 8 byte-wide
// RAM banks of BUF_BYTES/8 bytes, one per lane, so all bytes of a frame are written in the
// single bank-access cycle. The store needs no clearing after reset; reading a byte that was
// never written returns an unspecified value.
`timescale 1ns / 1ps
`default_nettype none
module can_transport_reassembly_core #(
   parameter int BUF_BYTES = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ctr_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ctr_pkg::rsp_type      rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready
);
   import ctr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DECODE = 4'b0010,
      S_ACCESS = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   req_type      item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   rsp_type      merged;
   logic [7:0]   fc_bs_ff, fc_st_ff;
   logic [11:0]  max_len_ff;
   lane_cmd_type cmd;
   rsp_type      res;
   logic [7:0]   lane_rd [LANES];
   logic         req_take;
   logic         rsp_take;
   logic         rsp_load;
   logic         csr_write;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_take) state_in = S_DECODE;
         S_DECODE: state_in = S_ACCESS;
         S_ACCESS: state_in = S_DONE;
         S_DONE:   if (rsp_load) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req_data;
      end
   end

   ctr_ctrl #(
      .BUF_BYTES(BUF_BYTES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .decode_en         (state_ff == S_DECODE),
      .item              (item_ff),
      .fc_block_size     (fc_bs_ff),
      .fc_separation_time(fc_st_ff),
      .max_msg_len       (max_len_ff),
      .cmd               (cmd),
      .res               (res)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      ctr_lane #(
         .LANE_IDX (g),
         .BUF_BYTES(BUF_BYTES)
      ) u_lane (
         .clock    (clock),
         .access_en(state_ff == S_ACCESS),
         .cmd      (cmd),
         .rd_data  (lane_rd[g])
      );
   end

   // merge: pick the bank that holds the addressed byte
   always_comb begin
      merged           = res;
      merged.read_data = cmd.rd ? lane_rd[cmd.base[2:0]] : 8'h00;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= merged;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_bs_ff   <= FC_BS_RESET;
         fc_st_ff   <= FC_ST_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            CSR_FC_BS:   fc_bs_ff   <= csr_pwdata[7:0];
            CSR_FC_ST:   fc_st_ff   <= csr_pwdata[7:0];
            CSR_MAX_LEN: max_len_ff <= csr_pwdata[11:0];
            default:     fc_bs_ff   <= fc_bs_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_FC_BS:   csr_prdata = {24'd0, fc_bs_ff};
         CSR_FC_ST:   csr_prdata = {24'd0, fc_st_ff};
         CSR_MAX_LEN: csr_prdata = {20'd0, max_len_ff};
         default:     csr_prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

[sv/ctr_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ctr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[sv/ctr_lane.sv]
// One byte lane: picks its byte of a bank command and drives its RAM bank.
`timescale 1ns / 1ps
`default_nettype none
module ctr_lane #(
   parameter int LANE_IDX  = 0,
   parameter int BUF_BYTES = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  access_en,
   input  wire ctr_pkg::lane_cmd_type cmd,
   output logic [7:0]                 rd_data
);
   import ctr_pkg::*;

   localparam int DEPTH = (BUF_BYTES + LANES - 1) / LANES;
   localparam int AW    = $clog2(DEPTH);

   logic [2:0]  lane_id;
   logic [2:0]  offset;
   logic        carry;
   logic [8:0]  row;
   logic        bank_we;
   logic [7:0]  bank_wdata;

   assign lane_id    = 3'(LANE_IDX);
   assign offset     = lane_id - cmd.base[2:0];
   assign carry      = lane_id < cmd.base[2:0];
   assign row        = cmd.base[11:3] + {8'd0, carry};
   assign bank_we    = access_en && cmd.we && (offset < cmd.count);
   assign bank_wdata = cmd.data[offset];

   ctr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_bank (
      .clock(clock),
      .we   (bank_we),
      .addr (row[AW-1:0]),
      .wdata(bank_wdata),
      .rdata(rd_data)
   );

endmodule
`default_nettype wire

[sv/ctr_ctrl.sv]
// Frame decoder and reception state of the reassembly core.
`timescale 1ns / 1ps
`default_nettype none
module ctr_ctrl #(
   parameter int BUF_BYTES = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  decode_en,
   input  wire ctr_pkg::req_type      item,
   input  wire logic [7:0]            fc_block_size,
   input  wire logic [7:0]            fc_separation_time,
   input  wire logic [11:0]           max_msg_len,
   output ctr_pkg::lane_cmd_type      cmd,
   output ctr_pkg::rsp_type           res
);
   import ctr_pkg::*;

   logic        receiving_ff, receiving_in;
   logic [11:0] total_length_ff, total_length_in;
   logic [11:0] write_index_ff, write_index_in;
   logic [3:0]  expected_seq_ff, expected_seq_in;
   lane_cmd_type cmd_ff, cmd_in;
   rsp_type      res_ff, res_in;

   logic [3:0]  pci_type;
   logic [3:0]  pci_low;
   logic [11:0] first_len;
   logic [12:0] diff;
   logic        last_block;
   logic [2:0]  cf_count;

   assign pci_type   = item.pci_byte[7:4];
   assign pci_low    = item.pci_byte[3:0];
   assign first_len  = {pci_low, item.frame_byte1};
   assign diff       = {1'b0, total_length_ff} - {1'b0, write_index_ff};
   assign last_block = diff[12] || (diff[11:3] == 9'd0);
   assign cf_count   = diff[12] ? 3'd0 : ((diff[11:3] != 9'd0) ? 3'd7 : diff[2:0]);

   always_comb begin
      receiving_in    = receiving_ff;
      total_length_in = total_length_ff;
      write_index_in  = write_index_ff;
      expected_seq_in = expected_seq_ff;
      cmd_in.we       = 1'b0;
      cmd_in.rd       = 1'b0;
      cmd_in.base     = 12'd0;
      cmd_in.count    = 3'd0;
      cmd_in.data     = {8'h00, item.frame_byte7, item.frame_byte6, item.frame_byte5,
                         item.frame_byte4, item.frame_byte3, item.frame_byte2,
                         item.frame_byte1};
      res_in          = '0;
      res_in.event_res = EV_IGNORED;
      if (item.func) begin
         res_in.event_res = EV_READ;
         cmd_in.base      = item.read_addr;
         cmd_in.rd        = 32'(item.read_addr) < BUF_BYTES;
      end else if (item.frame_dlc != 4'd0) begin
         unique case (pci_type)
            PCI_SINGLE: begin
               if (!pci_low[3]) begin
                  receiving_in     = 1'b0;
                  total_length_in  = {8'd0, pci_low};
                  write_index_in   = 12'd0;
                  cmd_in.we        = 1'b1;
                  cmd_in.count     = pci_low[2:0];
                  res_in.event_res = EV_SINGLE;
                  res_in.msg_len   = {8'd0, pci_low};
               end
            end
            PCI_FIRST: begin
               if (item.frame_dlc >= 4'd8 && first_len >= 12'd8) begin
                  if (first_len > max_msg_len || 32'(first_len) > BUF_BYTES) begin
                     receiving_in     = 1'b0;
                     res_in.event_res = EV_TOO_LONG;
                  end else begin
                     total_length_in  = first_len;
                     write_index_in   = 12'd6;
                     expected_seq_in  = 4'd1;
                     receiving_in     = 1'b1;
                     cmd_in.we        = 1'b1;
                     cmd_in.count     = 3'd6;
                     cmd_in.data      = {8'h00, 8'h00, item.frame_byte7, item.frame_byte6,
                                         item.frame_byte5, item.frame_byte4,
                                         item.frame_byte3, item.frame_byte2};
                     res_in.event_res = EV_FIRST;
                     res_in.fc_byte0  = FC_CTS;
                     res_in.fc_byte1  = fc_block_size;
                     res_in.fc_byte2  = fc_separation_time;
                  end
               end
            end
            PCI_CONSEC: begin
               if (receiving_ff) begin
                  if (pci_low != expected_seq_ff) begin
                     receiving_in     = 1'b0;
                     res_in.event_res = EV_ABORT;
                  end else begin
                     cmd_in.we       = 1'b1;
                     cmd_in.base     = write_index_ff;
                     cmd_in.count    = cf_count;
                     write_index_in  = write_index_ff + {9'd0, cf_count};
                     expected_seq_in = expected_seq_ff + 4'd1;
                     if (last_block) begin
                        receiving_in     = 1'b0;
                        res_in.event_res = EV_DELIVERED;
                        res_in.msg_len   = total_length_ff;
                     end else begin
                        res_in.event_res = EV_CONSEC;
                     end
                  end
               end
            end
            default: begin
               res_in.event_res = EV_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff    <= 1'b0;
         total_length_ff <= 12'd0;
         write_index_ff  <= 12'd0;
         expected_seq_ff <= 4'd0;
      end else if (decode_en) begin
         receiving_ff    <= receiving_in;
         total_length_ff <= total_length_in;
         write_index_ff  <= write_index_in;
         expected_seq_ff <= expected_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_en) begin
         cmd_ff <= cmd_in;
         res_ff <= res_in;
      end
   end

   assign cmd = cmd_ff;
   assign res = res_ff;

endmodule
`default_nettype wire

[sv/ctr_checker.sv]
// Port-level checker of the CAN transport reassembly core and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire ctr_pkg::rsp_type rsp_data
);
   import ctr_pkg::*;

   `ASSERT_CLK(a_one_at_a_time, clock, reset, (req_valid && !req_stall) |=> req_stall, "item taken while another is in flight")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "stalled result changed")
   `ASSERT_CLK(a_fc_only_first, clock, reset, (rsp_valid && rsp_data.event_res != EV_FIRST) |-> (rsp_data.fc_byte0 == 8'h00 && rsp_data.fc_byte1 == 8'h00 && rsp_data.fc_byte2 == 8'h00), "flow control bytes outside first frame")
   `ASSERT_CLK(a_fc_cts, clock, reset, (rsp_valid && rsp_data.event_res == EV_FIRST) |-> (rsp_data.fc_byte0 == FC_CTS && rsp_data.msg_len == 12'd0), "bad first frame reply")
   `ASSERT_CLK(a_len_only_done, clock, reset, (rsp_valid && rsp_data.event_res != EV_SINGLE && rsp_data.event_res != EV_DELIVERED) |-> (rsp_data.msg_len == 12'd0), "length outside delivery")

endmodule

bind can_transport_reassembly_core ctr_checker u_ctr_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
`default_nettype wire
